// ===== rtl/rti_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rti_pkg: shared types and constants of the ray-triangle intersection block
// Field widths, pipeline depths and the record passed from front to back.
// ============================================================================
package rti_pkg;

    localparam int COORD_W  = 16;   // one packed coordinate, signed Q8.8
    localparam int EDGE_W   = 17;   // vertex differences
    localparam int CRS_W    = 35;   // cross product components
    localparam int DOT_W    = 54;   // dot products (det, nu, nv, nt)
    localparam int T_FRAC   = 16;   // fraction bits of t
    localparam int UV_DROP  = 2;    // u, v carry 14 fraction bits, divider gives 16
    localparam int Q_BITS   = 31;   // quotient bits of the t/u/v divider
    localparam int DIV_LAT  = Q_BITS + 1;
    localparam int PT_LAT   = DIV_LAT + 3;
    localparam int M_W      = 20;   // normalized normal magnitude
    localparam int K_W      = 4;
    localparam int SQ_STEPS = 32;   // isqrt iterations, one per stage
    localparam int ND_STEPS = 15;   // normal quotient bits
    localparam int R_W      = 31;   // isqrt result width
    localparam int N_FRAC   = 24;   // m << 24 before the divide
    localparam int N_SHIFT  = N_FRAC - ND_STEPS;
    localparam int NRM_LAT  = 5 + SQ_STEPS + ND_STEPS + 1;
    localparam int DLY      = NRM_LAT - PT_LAT;
    localparam int OUT_ST   = NRM_LAT + 1;
    localparam int FRONT_ST = 7;
    localparam int FIFO_AW  = 2;

    // Cyclic neighbors for cross products.
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    // One classified test, handed from front to back.
    typedef struct packed {
        logic                          hit;
        logic                          tneg;
        logic [DOT_W-1:0]              tmag;
        logic [DOT_W-1:0]              nu;
        logic [DOT_W-1:0]              nv;
        logic [DOT_W-1:0]              den;
        logic [2:0][COORD_W-1:0]       o;
        logic [2:0][COORD_W-1:0]       d;
        logic [2:0][CRS_W-1:0]         n;
    } t_cls;

endpackage

// ===== rtl/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ray_triangle_intersect: pipelined Moller-Trumbore ray-triangle test
// One ray and one triangle per beat in; hit flag, t, hit point, unit
// normal and barycentric u, v per beat out.
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  test in   in         i_valid / o_ready    i_ray_origin, i_ray_direction,
//                                            i_vertex_a, i_vertex_b, i_vertex_c
//  result    out        o_valid / i_ready    o_hit, o_distance, o_point_*,
//                                            o_normal_*, o_bary_u, o_bary_v
//
//  Throughput is one test per cycle while o_ready is high. A test passes
//  through the front stages, the queue and the back stages; the back is
//  set by the normal path (scaling, a 32-step square root, a 15-step divide).
//  Reset clears the stage valids and queue pointers only; data registers
//  are not reset.
//  A stalled output freezes the back; the front keeps filling the
//  four-entry queue and drops o_ready only once the queue is full.
//
module ray_triangle_intersect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [47:0]          i_ray_origin,
    input  logic [47:0]          i_ray_direction,
    input  logic [47:0]          i_vertex_a,
    input  logic [47:0]          i_vertex_b,
    input  logic [47:0]          i_vertex_c,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic signed [31:0]   o_distance,
    output logic signed [15:0]   o_point_x,
    output logic signed [15:0]   o_point_y,
    output logic signed [15:0]   o_point_z,
    output logic signed [15:0]   o_normal_x,
    output logic signed [15:0]   o_normal_y,
    output logic signed [15:0]   o_normal_z,
    output logic signed [15:0]   o_bary_u,
    output logic signed [15:0]   o_bary_v
);

    rti_pkg::t_cls  cls, head;
    logic           push, pop, full, empty;

    // front: edges, cross/dot products, sign fix-up, hit classification
    rti_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_ray_origin    (i_ray_origin),
        .i_ray_direction (i_ray_direction),
        .i_vertex_a      (i_vertex_a),
        .i_vertex_b      (i_vertex_b),
        .i_vertex_c      (i_vertex_c),
        .i_fifo_full     (full),
        .o_push          (push),
        .o_cls           (cls)
    );

    // decouple the two halves so each can stall on its own
    rti_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // back: dividers, hit point, normal, output register
    rti_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_hit      (o_hit),
        .o_distance (o_distance),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_point_z  (o_point_z),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y),
        .o_normal_z (o_normal_z),
        .o_bary_u   (o_bary_u),
        .o_bary_v   (o_bary_v)
    );

endmodule

// ===== rtl/rti_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rti_front: geometry front end
// Forms edges, cross and dot products, normalizes the determinant sign and
// classifies hit or miss. Seven stages, one test per cycle while the queue has room.
// ============================================================================
module rti_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [47:0]          i_ray_origin,
    input  logic [47:0]          i_ray_direction,
    input  logic [47:0]          i_vertex_a,
    input  logic [47:0]          i_vertex_b,
    input  logic [47:0]          i_vertex_c,
    input  logic                 i_fifo_full,
    output logic                 o_push,
    output rti_pkg::t_cls        o_cls
);

    logic                              f_en;
    logic [rti_pkg::FRONT_ST-1:0]      r_fv;

    logic signed [rti_pkg::COORD_W-1:0] r1_o [3], r1_d [3];
    logic signed [rti_pkg::EDGE_W-1:0]  r1_e1 [3], r1_e2 [3], r1_s [3];
    logic signed [rti_pkg::EDGE_W-1:0]  n_e1 [3], n_e2 [3], n_s [3];

    logic signed [rti_pkg::COORD_W-1:0] r2_o [3], r2_d [3];
    logic signed [rti_pkg::EDGE_W-1:0]  r2_e1 [3], r2_s [3];
    logic signed [rti_pkg::CRS_W-1:0]   r2_pp [3], r2_pn [3], r2_qp [3], r2_qn [3];
    logic signed [rti_pkg::CRS_W-1:0]   r2_np [3], r2_nn [3];

    logic signed [rti_pkg::COORD_W-1:0] r3_o [3], r3_d [3];
    logic signed [rti_pkg::EDGE_W-1:0]  r3_e1 [3], r3_s [3];
    logic signed [rti_pkg::CRS_W-1:0]   r3_p [3], r3_q [3], r3_n [3];

    logic signed [rti_pkg::COORD_W-1:0] r4_o [3], r4_d [3];
    logic signed [rti_pkg::CRS_W-1:0]   r4_n [3];
    logic signed [rti_pkg::DOT_W-1:0]   r4_det [3], r4_nu [3], r4_nv [3], r4_nt [3];

    logic signed [rti_pkg::COORD_W-1:0] r5_o [3], r5_d [3];
    logic signed [rti_pkg::CRS_W-1:0]   r5_n [3];
    logic signed [rti_pkg::DOT_W-1:0]   r5_det, r5_nu, r5_nv, r5_nt;

    logic signed [rti_pkg::COORD_W-1:0] r6_o [3], r6_d [3];
    logic signed [rti_pkg::CRS_W-1:0]   r6_n [3];
    logic signed [rti_pkg::DOT_W-1:0]   r6_det, r6_nu, r6_nv, r6_nt;

    rti_pkg::t_cls                      r_cls, n_cls;
    logic signed [rti_pkg::DOT_W:0]     uv_sum;

    assign f_en    = !r_fv[rti_pkg::FRONT_ST-1] || !i_fifo_full;
    assign o_ready = f_en;
    assign o_push  = r_fv[rti_pkg::FRONT_ST-1] && !i_fifo_full;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (f_en) begin
            r_fv <= {r_fv[rti_pkg::FRONT_ST-2:0], i_valid};
        end
    end

    // edges and origin offset
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e1[i] = rti_pkg::EDGE_W'($signed(i_vertex_b[16*i +: 16]))
                    - rti_pkg::EDGE_W'($signed(i_vertex_a[16*i +: 16]));
            n_e2[i] = rti_pkg::EDGE_W'($signed(i_vertex_c[16*i +: 16]))
                    - rti_pkg::EDGE_W'($signed(i_vertex_a[16*i +: 16]));
            n_s[i]  = rti_pkg::EDGE_W'($signed(i_ray_origin[16*i +: 16]))
                    - rti_pkg::EDGE_W'($signed(i_vertex_a[16*i +: 16]));
        end
    end

    always_comb begin
        uv_sum = (rti_pkg::DOT_W+1)'(r6_nu) + (rti_pkg::DOT_W+1)'(r6_nv);
        n_cls.hit  = (r6_det != '0) && !r6_nu[rti_pkg::DOT_W-1] && (r6_nu <= r6_det)
                   && !r6_nv[rti_pkg::DOT_W-1]
                   && (uv_sum <= (rti_pkg::DOT_W+1)'(r6_det));
        n_cls.tneg = r6_nt[rti_pkg::DOT_W-1];
        n_cls.tmag = r6_nt[rti_pkg::DOT_W-1] ? rti_pkg::DOT_W'(-r6_nt) : r6_nt;
        n_cls.nu   = r6_nu;
        n_cls.nv   = r6_nv;
        n_cls.den  = r6_det;
        for (int i = 0; i < 3; i++) begin
            n_cls.o[i] = r6_o[i];
            n_cls.d[i] = r6_d[i];
            n_cls.n[i] = r6_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            for (int i = 0; i < 3; i++) begin
                // stage 1
                r1_o[i]  <= $signed(i_ray_origin[16*i +: 16]);
                r1_d[i]  <= $signed(i_ray_direction[16*i +: 16]);
                r1_e1[i] <= n_e1[i];
                r1_e2[i] <= n_e2[i];
                r1_s[i]  <= n_s[i];
                // stage 2: cross product terms
                r2_o[i]  <= r1_o[i];
                r2_d[i]  <= r1_d[i];
                r2_e1[i] <= r1_e1[i];
                r2_s[i]  <= r1_s[i];
                r2_pp[i] <= rti_pkg::CRS_W'(r1_d[rti_pkg::NXT[i]])
                          * rti_pkg::CRS_W'(r1_e2[rti_pkg::PRV[i]]);
                r2_pn[i] <= rti_pkg::CRS_W'(r1_d[rti_pkg::PRV[i]])
                          * rti_pkg::CRS_W'(r1_e2[rti_pkg::NXT[i]]);
                r2_qp[i] <= rti_pkg::CRS_W'(r1_s[rti_pkg::NXT[i]])
                          * rti_pkg::CRS_W'(r1_e1[rti_pkg::PRV[i]]);
                r2_qn[i] <= rti_pkg::CRS_W'(r1_s[rti_pkg::PRV[i]])
                          * rti_pkg::CRS_W'(r1_e1[rti_pkg::NXT[i]]);
                r2_np[i] <= rti_pkg::CRS_W'(r1_e1[rti_pkg::NXT[i]])
                          * rti_pkg::CRS_W'(r1_e2[rti_pkg::PRV[i]]);
                r2_nn[i] <= rti_pkg::CRS_W'(r1_e1[rti_pkg::PRV[i]])
                          * rti_pkg::CRS_W'(r1_e2[rti_pkg::NXT[i]]);
                // stage 3
                r3_o[i]  <= r2_o[i];
                r3_d[i]  <= r2_d[i];
                r3_e1[i] <= r2_e1[i];
                r3_s[i]  <= r2_s[i];
                r3_p[i]  <= r2_pp[i] - r2_pn[i];
                r3_q[i]  <= r2_qp[i] - r2_qn[i];
                r3_n[i]  <= r2_np[i] - r2_nn[i];
                // stage 4: dot product terms
                r4_o[i]   <= r3_o[i];
                r4_d[i]   <= r3_d[i];
                r4_n[i]   <= r3_n[i];
                r4_det[i] <= rti_pkg::DOT_W'(r3_e1[i]) * rti_pkg::DOT_W'(r3_p[i]);
                r4_nu[i]  <= rti_pkg::DOT_W'(r3_s[i]) * rti_pkg::DOT_W'(r3_p[i]);
                r4_nv[i]  <= rti_pkg::DOT_W'(r3_d[i]) * rti_pkg::DOT_W'(r3_q[i]);
                r4_nt[i]  <= rti_pkg::DOT_W'(r3_n[i]) * rti_pkg::DOT_W'(r3_s[i]);
                // stages 5 and 6
                r5_o[i] <= r4_o[i];
                r5_d[i] <= r4_d[i];
                r5_n[i] <= r4_n[i];
                r6_o[i] <= r5_o[i];
                r6_d[i] <= r5_d[i];
                r6_n[i] <= r5_n[i];
            end
            r5_det <= r4_det[0] + r4_det[1] + r4_det[2];
            r5_nu  <= r4_nu[0] + r4_nu[1] + r4_nu[2];
            r5_nv  <= r4_nv[0] + r4_nv[1] + r4_nv[2];
            r5_nt  <= r4_nt[0] + r4_nt[1] + r4_nt[2];
            // flip all four so the determinant is never negative
            r6_det <= r5_det[rti_pkg::DOT_W-1] ? -r5_det : r5_det;
            r6_nu  <= r5_det[rti_pkg::DOT_W-1] ? -r5_nu  : r5_nu;
            r6_nv  <= r5_det[rti_pkg::DOT_W-1] ? -r5_nv  : r5_nv;
            r6_nt  <= r5_det[rti_pkg::DOT_W-1] ? -r5_nt  : r5_nt;
            r_cls  <= n_cls;
        end
    end

endmodule

// ===== rtl/rti_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rti_fifo: short queue between front and back
// Four entries of classified tests; head is read straight from the array.
// ============================================================================
module rti_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rti_pkg::t_cls   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output rti_pkg::t_cls   o_head
);

    rti_pkg::t_cls            r_mem [2**rti_pkg::FIFO_AW];
    logic [rti_pkg::FIFO_AW:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[rti_pkg::FIFO_AW] != r_rp[rti_pkg::FIFO_AW])
                  && (r_wp[rti_pkg::FIFO_AW-1:0] == r_rp[rti_pkg::FIFO_AW-1:0]);
    assign o_head  = r_mem[r_rp[rti_pkg::FIFO_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[rti_pkg::FIFO_AW-1:0]] <= i_data;
        end
    end

endmodule

// ===== rtl/rti_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rti_div: pipelined restoring divider
// floor(num * 2^16 / den), clamped to 2^31; one quotient bit per stage.
// ============================================================================
module rti_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rti_pkg::DOT_W-1:0]   i_num,
    input  logic [rti_pkg::DOT_W-1:0]   i_den,
    output logic [31:0]                 o_q
);

    localparam int LO_W = rti_pkg::Q_BITS - rti_pkg::T_FRAC;

    logic [rti_pkg::DOT_W-1:0]  r_rem [rti_pkg::DIV_LAT];
    logic [rti_pkg::DOT_W-1:0]  r_den [rti_pkg::DIV_LAT];
    logic [LO_W-1:0]            r_lo  [rti_pkg::DIV_LAT];
    logic [rti_pkg::Q_BITS-1:0] r_q   [rti_pkg::DIV_LAT];
    logic                       r_ovf [rti_pkg::DIV_LAT];

    // first stage: upper part of the scaled numerator, overflow check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= rti_pkg::DOT_W'(i_num[rti_pkg::DOT_W-1:LO_W]);
            r_lo[0]  <= i_num[LO_W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= rti_pkg::DOT_W'(i_num[rti_pkg::DOT_W-1:LO_W]) >= i_den;
        end
    end

    for (genvar j = 1; j < rti_pkg::DIV_LAT; j++) begin : g_st
        localparam int B = rti_pkg::DIV_LAT - 1 - j;
        logic                       xb;
        logic [rti_pkg::DOT_W:0]    tr;
        logic                       ge;
        if (B >= rti_pkg::T_FRAC) begin : g_bit
            assign xb = r_lo[j-1][B-rti_pkg::T_FRAC];
        end else begin : g_zero
            assign xb = 1'b0;
        end
        assign tr = {r_rem[j-1], xb};
        assign ge = tr >= {1'b0, r_den[j-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? rti_pkg::DOT_W'(tr - {1'b0, r_den[j-1]})
                               : tr[rti_pkg::DOT_W-1:0];
                r_lo[j]  <= r_lo[j-1];
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_q[j]   <= r_q[j-1] | (rti_pkg::Q_BITS'(ge) << B);
            end
        end
    end

    assign o_q = r_ovf[rti_pkg::DIV_LAT-1] ? 32'h8000_0000
                                           : {1'b0, r_q[rti_pkg::DIV_LAT-1]};

endmodule

// ===== rtl/rti_norm.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rti_norm: unit face normal
// Scales |N| below 2^20, forms an integer square root one step per stage,
// then divides each component one quotient bit per stage.
// ============================================================================
module rti_norm (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [2:0][rti_pkg::CRS_W-1:0]      i_n,
    output logic [2:0][15:0]                    o_n
);

    localparam int A_W = rti_pkg::CRS_W - 1;

    logic [2:0][A_W-1:0]           r1_a, r2_a, n_a;
    logic [2:0]                    r1_sg, r2_sg, r3_sg, r4_sg, r5_sg, n_sg;
    logic [rti_pkg::K_W-1:0]       r2_k, n_k;
    logic [A_W-1:0]                orv;
    logic [2:0][rti_pkg::M_W-1:0]  r3_m, r4_m, r5_m;
    logic [2:0][2*rti_pkg::M_W-1:0] r4_sq;
    logic [63:0]                   r5_x;

    logic [63:0]                   r_sx  [rti_pkg::SQ_STEPS];
    logic [63:0]                   r_sr  [rti_pkg::SQ_STEPS];
    logic [2:0][rti_pkg::M_W-1:0]  r_sm  [rti_pkg::SQ_STEPS];
    logic [2:0]                    r_ssg [rti_pkg::SQ_STEPS];

    logic [2:0][rti_pkg::R_W-1:0]      r_drem [rti_pkg::ND_STEPS];
    logic [2:0][rti_pkg::ND_STEPS-1:0] r_dq   [rti_pkg::ND_STEPS];
    logic [rti_pkg::R_W-1:0]           r_dr   [rti_pkg::ND_STEPS];
    logic                              r_dz   [rti_pkg::ND_STEPS];
    logic [2:0]                        r_dsg  [rti_pkg::ND_STEPS];

    logic [2:0][15:0]              r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sg[i] = i_n[i][rti_pkg::CRS_W-1];
            n_a[i]  = n_sg[i] ? A_W'(-$signed(i_n[i])) : i_n[i][A_W-1:0];
        end
    end

    // shift that brings every magnitude below 2^20
    always_comb begin
        orv = r1_a[0] | r1_a[1] | r1_a[2];
        n_k = '0;
        for (int i = rti_pkg::M_W; i < A_W; i++) begin
            if (orv[i]) begin
                n_k = rti_pkg::K_W'(i - rti_pkg::M_W + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= n_a;
            r1_sg <= n_sg;
            r2_a  <= r1_a;
            r2_k  <= n_k;
            r2_sg <= r1_sg;
            for (int i = 0; i < 3; i++) begin
                r3_m[i]  <= rti_pkg::M_W'(r2_a[i] >> r2_k);
                r4_sq[i] <= r3_m[i] * r3_m[i];
            end
            r3_sg <= r2_sg;
            r4_m  <= r3_m;
            r4_sg <= r3_sg;
            r5_x  <= {2'b0, (2*rti_pkg::M_W+2)'(r4_sq[0]) + (2*rti_pkg::M_W+2)'(r4_sq[1])
                           + (2*rti_pkg::M_W+2)'(r4_sq[2]), 20'b0};
            r5_m  <= r4_m;
            r5_sg <= r4_sg;
        end
    end

    for (genvar j = 0; j < rti_pkg::SQ_STEPS; j++) begin : g_sq
        localparam logic [63:0] BV = 64'd1 << (2*(rti_pkg::SQ_STEPS-1-j));
        logic [63:0]                  x_in, r_in, rb;
        logic [2:0][rti_pkg::M_W-1:0] m_in;
        logic [2:0]                   sg_in;
        logic                         ge;
        if (j == 0) begin : g_first
            assign x_in  = r5_x;
            assign r_in  = '0;
            assign m_in  = r5_m;
            assign sg_in = r5_sg;
        end else begin : g_next
            assign x_in  = r_sx[j-1];
            assign r_in  = r_sr[j-1];
            assign m_in  = r_sm[j-1];
            assign sg_in = r_ssg[j-1];
        end
        assign rb = r_in + BV;
        assign ge = x_in >= rb;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sx[j]  <= ge ? x_in - rb : x_in;
                r_sr[j]  <= ge ? (r_in >> 1) + BV : r_in >> 1;
                r_sm[j]  <= m_in;
                r_ssg[j] <= sg_in;
            end
        end
    end

    for (genvar d = 0; d < rti_pkg::ND_STEPS; d++) begin : g_dv
        localparam int B = rti_pkg::ND_STEPS - 1 - d;
        logic [2:0][rti_pkg::R_W-1:0]      rem_in, rem_nx;
        logic [2:0][rti_pkg::ND_STEPS-1:0] q_in, q_nx;
        logic [rti_pkg::R_W-1:0]           den;
        logic                              z_in;
        logic [2:0]                        sg_in;
        if (d == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = rti_pkg::R_W'({r_sm[rti_pkg::SQ_STEPS-1][i],
                                               rti_pkg::N_SHIFT'(0)});
                end
            end
            assign q_in  = '0;
            assign den   = r_sr[rti_pkg::SQ_STEPS-1][rti_pkg::R_W-1:0];
            assign z_in  = (r_sr[rti_pkg::SQ_STEPS-1][rti_pkg::R_W-1:0] == '0);
            assign sg_in = r_ssg[rti_pkg::SQ_STEPS-1];
        end else begin : g_next
            assign rem_in = r_drem[d-1];
            assign q_in   = r_dq[d-1];
            assign den    = r_dr[d-1];
            assign z_in   = r_dz[d-1];
            assign sg_in  = r_dsg[d-1];
        end
        always_comb begin
            logic [rti_pkg::R_W:0] tr;
            for (int i = 0; i < 3; i++) begin
                tr = {rem_in[i], 1'b0};
                if (tr >= {1'b0, den}) begin
                    rem_nx[i] = rti_pkg::R_W'(tr - {1'b0, den});
                    q_nx[i]   = q_in[i] | (rti_pkg::ND_STEPS'(1) << B);
                end else begin
                    rem_nx[i] = tr[rti_pkg::R_W-1:0];
                    q_nx[i]   = q_in[i];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[d] <= rem_nx;
                r_dq[d]   <= q_nx;
                r_dr[d]   <= den;
                r_dz[d]   <= z_in;
                r_dsg[d]  <= sg_in;
            end
        end
    end

    // apply signs; a zero root means a zero normal
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dz[rti_pkg::ND_STEPS-1]) begin
                    r_out[i] <= '0;
                end else if (r_dsg[rti_pkg::ND_STEPS-1][i]) begin
                    r_out[i] <= -(16'(r_dq[rti_pkg::ND_STEPS-1][i]));
                end else begin
                    r_out[i] <= 16'(r_dq[rti_pkg::ND_STEPS-1][i]);
                end
            end
        end
    end

    assign o_n = r_out;

endmodule

// ===== rtl/rti_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rti_back: result back end
// Divides out t, u and v, forms the hit point and the unit normal, aligns
// them and holds the result in the output register.
// ============================================================================
module rti_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  rti_pkg::t_cls        i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic signed [31:0]   o_distance,
    output logic signed [15:0]   o_point_x,
    output logic signed [15:0]   o_point_y,
    output logic signed [15:0]   o_point_z,
    output logic signed [15:0]   o_normal_x,
    output logic signed [15:0]   o_normal_y,
    output logic signed [15:0]   o_normal_z,
    output logic signed [15:0]   o_bary_u,
    output logic signed [15:0]   o_bary_v
);

    typedef struct packed {
        logic                                 hit;
        logic                                 tneg;
        logic [2:0][rti_pkg::COORD_W-1:0]     o;
        logic [2:0][rti_pkg::COORD_W-1:0]     d;
    } t_side;

    typedef struct packed {
        logic               hit;
        logic [31:0]        t;
        logic [2:0][15:0]   pt;
        logic [15:0]        u;
        logic [15:0]        v;
    } t_res;

    logic                          b_en;
    logic [rti_pkg::OUT_ST-1:0]    r_vld;
    logic [31:0]                   q_t, q_u, q_v;
    logic [2:0][15:0]              nrm;
    t_side                         r_side [rti_pkg::DIV_LAT];

    logic                          r1_hit, r2_hit;
    logic signed [31:0]            r1_t, r2_t;
    logic [15:0]                   r1_u, r1_v, r2_u, r2_v;
    logic [2:0][rti_pkg::COORD_W-1:0] r1_o, r1_d, r2_o;
    logic signed [47:0]            r2_pr [3];
    t_res                          r_dl [rti_pkg::DLY+1];
    t_res                          n_b3;

    function automatic logic [15:0] sat16(input logic signed [32:0] x);
        if (x > 33'sd32767) begin
            return 16'h7FFF;
        end else if (x < -33'sd32768) begin
            return 16'h8000;
        end
        return x[15:0];
    endfunction

    // the whole back pipeline freezes while a result waits at the output
    assign b_en    = !r_vld[rti_pkg::OUT_ST-1] || i_ready;
    assign o_pop   = !i_empty && b_en;
    assign o_valid = r_vld[rti_pkg::OUT_ST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (b_en) begin
            r_vld <= {r_vld[rti_pkg::OUT_ST-2:0], o_pop};
        end
    end

    rti_div u_div_t (.i_clk(i_clk), .i_en(b_en), .i_num(i_head.tmag),
                     .i_den(i_head.den), .o_q(q_t));
    rti_div u_div_u (.i_clk(i_clk), .i_en(b_en), .i_num(i_head.nu),
                     .i_den(i_head.den), .o_q(q_u));
    rti_div u_div_v (.i_clk(i_clk), .i_en(b_en), .i_num(i_head.nv),
                     .i_den(i_head.den), .o_q(q_v));
    rti_norm u_norm (.i_clk(i_clk), .i_en(b_en), .i_n(i_head.n), .o_n(nrm));

    // carry ray data alongside the dividers
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_side[0] <= '{hit: i_head.hit, tneg: i_head.tneg, o: i_head.o, d: i_head.d};
            for (int j = 1; j < rti_pkg::DIV_LAT; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    always_comb begin
        n_b3.hit = r2_hit;
        n_b3.t   = r2_t;
        n_b3.u   = r2_u;
        n_b3.v   = r2_v;
        for (int i = 0; i < 3; i++) begin
            n_b3.pt[i] = sat16(33'($signed(r2_o[i])) + 33'(r2_pr[i] >>> rti_pkg::T_FRAC));
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            // signed t from quotient magnitude
            r1_hit <= r_side[rti_pkg::DIV_LAT-1].hit;
            if (r_side[rti_pkg::DIV_LAT-1].tneg) begin
                r1_t <= -$signed(q_t);
            end else if (q_t[31]) begin
                r1_t <= 32'sh7FFF_FFFF;
            end else begin
                r1_t <= $signed(q_t);
            end
            r1_u <= q_u[rti_pkg::UV_DROP +: 16];
            r1_v <= q_v[rti_pkg::UV_DROP +: 16];
            r1_o <= r_side[rti_pkg::DIV_LAT-1].o;
            r1_d <= r_side[rti_pkg::DIV_LAT-1].d;
            // t * D
            r2_hit <= r1_hit;
            r2_t   <= r1_t;
            r2_u   <= r1_u;
            r2_v   <= r1_v;
            r2_o   <= r1_o;
            for (int i = 0; i < 3; i++) begin
                r2_pr[i] <= 48'(r1_t) * 48'($signed(r1_d[i]));
            end
            // point, then align with the normal
            r_dl[0] <= n_b3;
            for (int j = 1; j <= rti_pkg::DLY; j++) begin
                r_dl[j] <= r_dl[j-1];
            end
        end
    end

    // output register; a miss reports all zeros
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            o_hit <= r_dl[rti_pkg::DLY].hit;
            if (r_dl[rti_pkg::DLY].hit) begin
                o_distance <= r_dl[rti_pkg::DLY].t;
                o_point_x  <= r_dl[rti_pkg::DLY].pt[0];
                o_point_y  <= r_dl[rti_pkg::DLY].pt[1];
                o_point_z  <= r_dl[rti_pkg::DLY].pt[2];
                o_normal_x <= nrm[0];
                o_normal_y <= nrm[1];
                o_normal_z <= nrm[2];
                o_bary_u   <= r_dl[rti_pkg::DLY].u;
                o_bary_v   <= r_dl[rti_pkg::DLY].v;
            end else begin
                o_distance <= '0;
                o_point_x  <= '0;
                o_point_y  <= '0;
                o_point_z  <= '0;
                o_normal_x <= '0;
                o_normal_y <= '0;
                o_normal_z <= '0;
                o_bary_u   <= '0;
                o_bary_v   <= '0;
            end
        end
    end

endmodule
